// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rasterizer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// plain invariant checked on every rising edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

// ===== sv/ttr_pkg.sv =====
// ----------------------------------------------------------------------------
// ttr_pkg
// shared types, widths and helpers of the tile rasterizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttr_pkg;

    localparam int TILE_SIZE        = 8;
    localparam int COORD_FRAC_BITS  = 4;
    localparam int WEIGHT_FRAC_BITS = 14;

    localparam int COORD_W  = 7;
    localparam int PIX_W    = 3;
    localparam int WEIGHT_W = 18;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int DET_W    = PROD_W + 1;
    localparam int DIV_W    = DET_W + 1;
    localparam int NUM_W    = PROD_W + 2;
    localparam int NDIV_W   = NUM_W + WEIGHT_FRAC_BITS + 2;
    localparam int WA_W     = NDIV_W + 2;
    localparam int QDEPTH   = 2;
    localparam int NUM_DIVS = 6;

    localparam logic [COORD_W-1:0] COORD_LIM =
        COORD_W'((TILE_SIZE - 1) << COORD_FRAC_BITS);
    localparam logic [DIFF_W-1:0] FRAC_MASK = DIFF_W'((1 << COORD_FRAC_BITS) - 1);
    localparam logic signed [WA_W-1:0] W_ONE = signed'(WA_W'(1 << WEIGHT_FRAC_BITS));
    localparam logic signed [WA_W-1:0] W_MAX = signed'(WA_W'((1 << (WEIGHT_W - 1)) - 1));
    localparam logic signed [WA_W-1:0] W_MIN = -signed'(WA_W'(1 << (WEIGHT_W - 1)));

    typedef enum logic [1:0] {
        ST_COVERED = 2'd0,
        ST_NONE    = 2'd1,
        ST_DEGEN   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DELTA,
        F_PROD,
        F_SUM,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_WAIT,
        B_SCAN,
        B_FINISH
    } back_state_t;

    typedef struct packed {
        logic                     degen;
        logic [PIX_W-1:0]         bx0;
        logic [PIX_W-1:0]         by0;
        logic [PIX_W-1:0]         bx1;
        logic [PIX_W-1:0]         by1;
        logic [DIV_W-1:0]         dval;
        logic signed [NDIV_W-1:0] nb0;
        logic signed [NDIV_W-1:0] nc0;
        logic signed [NDIV_W-1:0] nbc;
        logic signed [NDIV_W-1:0] ncc;
        logic signed [NDIV_W-1:0] nbr;
        logic signed [NDIV_W-1:0] ncr;
    } desc_t;

    typedef struct packed {
        logic signed [NDIV_W-1:0] q;
        logic [DIV_W-1:0]         r;
    } qr_t;

    // quotient and remainder of a sum of two dividends over the same divisor
    function automatic qr_t qr_add(qr_t a, qr_t s, logic [DIV_W-1:0] d);
        logic [DIV_W:0] sum;
        qr_t            res;
        sum = {1'b0, a.r} + {1'b0, s.r};
        if (sum >= {1'b0, d})
        begin
            res.q = a.q + s.q + NDIV_W'(1);
            res.r = DIV_W'(sum - {1'b0, d});
        end
        else
        begin
            res.q = a.q + s.q;
            res.r = DIV_W'(sum);
        end
        return res;
    endfunction

    function automatic logic [WEIGHT_W-1:0] sat_w(logic signed [WA_W-1:0] w);
        logic signed [WA_W-1:0] c;
        c = w;
        if (w > W_MAX)
        begin
            c = W_MAX;
        end
        if (w < W_MIN)
        begin
            c = W_MIN;
        end
        return c[WEIGHT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/ttr_front.sv =====
// ----------------------------------------------------------------------------
// ttr_front
// takes a triangle, works out box, determinant and edge numerators
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttr_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [ttr_pkg::COORD_W-1:0]  vertex0_x,
    input  wire logic [ttr_pkg::COORD_W-1:0]  vertex0_y,
    input  wire logic [ttr_pkg::COORD_W-1:0]  vertex1_x,
    input  wire logic [ttr_pkg::COORD_W-1:0]  vertex1_y,
    input  wire logic [ttr_pkg::COORD_W-1:0]  vertex2_x,
    input  wire logic [ttr_pkg::COORD_W-1:0]  vertex2_y,
    input  wire logic                         q_full,
    output logic                              q_push,
    output ttr_pkg::desc_t                    q_data
);
    import ttr_pkg::*;

    front_state_t state_reg, state_next;

    logic [COORD_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [DIFF_W-1:0] ax_reg, ay_reg, bx_reg, by_reg, dx_reg, dy_reg;
    logic [PIX_W-1:0] bx0_reg, by0_reg, bx1_reg, by1_reg;
    logic signed [PROD_W-1:0] p_aby_reg, p_ayb_reg, p_bydx_reg, p_bxdy_reg;
    logic signed [PROD_W-1:0] p_axdy_reg, p_aydx_reg;
    desc_t desc_reg, desc_next;

    logic signed [DIFF_W-1:0] ax_next, ay_next, bx_next, by_next, dx_next, dy_next;
    logic [PIX_W-1:0] bx0_next, by0_next, bx1_next, by1_next;

    function automatic logic [COORD_W-1:0] clamp(logic [COORD_W-1:0] v);
        return (v > COORD_LIM) ? COORD_LIM : v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        q_push     = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = F_DELTA;
                end
            end
            F_DELTA: state_next = F_PROD;
            F_PROD:  state_next = F_SUM;
            F_SUM:   state_next = F_PUSH;
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // edge vectors and pixel box
    always_comb
    begin
        logic [COORD_W-1:0] mnx, mny, mxx, mxy;
        mnx = (x0_reg < x1_reg) ? x0_reg : x1_reg;
        mnx = (x2_reg < mnx) ? x2_reg : mnx;
        mny = (y0_reg < y1_reg) ? y0_reg : y1_reg;
        mny = (y2_reg < mny) ? y2_reg : mny;
        mxx = (x0_reg > x1_reg) ? x0_reg : x1_reg;
        mxx = (x2_reg > mxx) ? x2_reg : mxx;
        mxy = (y0_reg > y1_reg) ? y0_reg : y1_reg;
        mxy = (y2_reg > mxy) ? y2_reg : mxy;
        ax_next  = signed'(DIFF_W'(x1_reg)) - signed'(DIFF_W'(x0_reg));
        ay_next  = signed'(DIFF_W'(y1_reg)) - signed'(DIFF_W'(y0_reg));
        bx_next  = signed'(DIFF_W'(x2_reg)) - signed'(DIFF_W'(x0_reg));
        by_next  = signed'(DIFF_W'(y2_reg)) - signed'(DIFF_W'(y0_reg));
        bx0_next = PIX_W'(mnx >> COORD_FRAC_BITS);
        by0_next = PIX_W'(mny >> COORD_FRAC_BITS);
        bx1_next = PIX_W'((DIFF_W'(mxx) + FRAC_MASK) >> COORD_FRAC_BITS);
        by1_next = PIX_W'((DIFF_W'(mxy) + FRAC_MASK) >> COORD_FRAC_BITS);
        dx_next  = signed'(DIFF_W'(bx0_next) << COORD_FRAC_BITS) - signed'(DIFF_W'(x0_reg));
        dy_next  = signed'(DIFF_W'(by0_next) << COORD_FRAC_BITS) - signed'(DIFF_W'(y0_reg));
    end

    // sign-normalised numerators, scaled for the rounding divide
    always_comb
    begin
        logic signed [DET_W-1:0] det, adet;
        logic signed [NUM_W-1:0] n1, n2, cb, cc, rb, rc;
        logic                    neg;
        det  = DET_W'(p_aby_reg) - DET_W'(p_ayb_reg);
        neg  = det < 0;
        adet = neg ? -det : det;
        n1 = NUM_W'(p_bydx_reg) - NUM_W'(p_bxdy_reg);
        n2 = NUM_W'(p_axdy_reg) - NUM_W'(p_aydx_reg);
        cb = NUM_W'(by_reg) <<< COORD_FRAC_BITS;
        cc = -(NUM_W'(ay_reg) <<< COORD_FRAC_BITS);
        rb = -(NUM_W'(bx_reg) <<< COORD_FRAC_BITS);
        rc = NUM_W'(ax_reg) <<< COORD_FRAC_BITS;
        if (neg)
        begin
            n1 = -n1;
            n2 = -n2;
            cb = -cb;
            cc = -cc;
            rb = -rb;
            rc = -rc;
        end
        desc_next.degen = (det == 0);
        desc_next.bx0   = bx0_reg;
        desc_next.by0   = by0_reg;
        desc_next.bx1   = bx1_reg;
        desc_next.by1   = by1_reg;
        desc_next.dval  = DIV_W'(adet) << 1;
        desc_next.nb0   = (NDIV_W'(n1) <<< (WEIGHT_FRAC_BITS + 1)) + NDIV_W'(adet);
        desc_next.nc0   = (NDIV_W'(n2) <<< (WEIGHT_FRAC_BITS + 1)) + NDIV_W'(adet);
        desc_next.nbc   = NDIV_W'(cb) <<< (WEIGHT_FRAC_BITS + 1);
        desc_next.ncc   = NDIV_W'(cc) <<< (WEIGHT_FRAC_BITS + 1);
        desc_next.nbr   = NDIV_W'(rb) <<< (WEIGHT_FRAC_BITS + 1);
        desc_next.ncr   = NDIV_W'(rc) <<< (WEIGHT_FRAC_BITS + 1);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid)
        begin
            x0_reg <= clamp(vertex0_x);
            y0_reg <= clamp(vertex0_y);
            x1_reg <= clamp(vertex1_x);
            y1_reg <= clamp(vertex1_y);
            x2_reg <= clamp(vertex2_x);
            y2_reg <= clamp(vertex2_y);
        end
        if (state_reg == F_DELTA)
        begin
            ax_reg  <= ax_next;
            ay_reg  <= ay_next;
            bx_reg  <= bx_next;
            by_reg  <= by_next;
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            bx0_reg <= bx0_next;
            by0_reg <= by0_next;
            bx1_reg <= bx1_next;
            by1_reg <= by1_next;
        end
        if (state_reg == F_PROD)
        begin
            p_aby_reg  <= ax_reg * by_reg;
            p_ayb_reg  <= ay_reg * bx_reg;
            p_bydx_reg <= by_reg * dx_reg;
            p_bxdy_reg <= bx_reg * dy_reg;
            p_axdy_reg <= ax_reg * dy_reg;
            p_aydx_reg <= ay_reg * dx_reg;
        end
        if (state_reg == F_SUM)
        begin
            desc_reg <= desc_next;
        end
    end

    assign q_data = desc_reg;

endmodule

`default_nettype wire

// ===== sv/ttr_queue.sv =====
// ----------------------------------------------------------------------------
// ttr_queue
// short queue of triangle setups between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttr_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire ttr_pkg::desc_t push_data,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output ttr_pkg::desc_t      data
);
    import ttr_pkg::*;
    `include "assert_macros.svh"

    // depth is a power of two so the pointers wrap on their own
    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    desc_t             entry_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full  = (count_reg == CNT_W'(QDEPTH));
    assign valid = (count_reg != '0);
    assign data  = entry_reg[rd_ptr_reg];

    `ASSERT_IMPL(a_no_overflow, push, !full, "push into a full queue")
    `ASSERT_IMPL(a_no_underflow, pop, valid, "pop from an empty queue")
    `ASSERT_ALWAYS(a_count_range, count_reg <= CNT_W'(QDEPTH), "queue count out of range")

endmodule

`default_nettype wire

// ===== sv/ttr_div.sv =====
// ----------------------------------------------------------------------------
// ttr_div
// radix-2 floor divider, signed dividend over positive divisor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttr_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [ttr_pkg::NDIV_W-1:0]   dividend,
    input  wire logic [ttr_pkg::DIV_W-1:0]           divisor,
    output logic                                     done,
    output ttr_pkg::qr_t                             result
);
    import ttr_pkg::*;

    localparam int CNT_W = $clog2(NDIV_W + 1);

    logic               busy_reg, fix_reg, done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               neg_reg;
    logic [NDIV_W-1:0]  mag_reg, quo_reg;
    logic [DIV_W-1:0]   rem_reg, d_reg;
    qr_t                res_reg;
    logic [DIV_W:0]     trial;
    logic               take;

    assign trial = {rem_reg, mag_reg[NDIV_W-1]};
    assign take  = trial >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fix_reg;
            fix_reg  <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NDIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend < 0;
            mag_reg <= (dividend < 0) ? NDIV_W'(-dividend) : NDIV_W'(dividend);
            d_reg   <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            mag_reg <= mag_reg << 1;
            quo_reg <= {quo_reg[NDIV_W-2:0], take};
            rem_reg <= take ? DIV_W'(trial - {1'b0, d_reg}) : DIV_W'(trial);
        end
        if (fix_reg)
        begin
            if (!neg_reg)
            begin
                res_reg.q <= signed'(quo_reg);
                res_reg.r <= rem_reg;
            end
            else if (rem_reg == '0)
            begin
                res_reg.q <= -signed'(quo_reg);
                res_reg.r <= '0;
            end
            else
            begin
                res_reg.q <= signed'(~quo_reg);
                res_reg.r <= d_reg - rem_reg;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// ===== sv/ttr_back.sv =====
// ----------------------------------------------------------------------------
// ttr_back
// divides setup into weights, scans the box one pixel a cycle unless stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttr_back (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic signed [ttr_pkg::WEIGHT_W-1:0]  tol,
    input  wire logic                                 q_valid,
    input  wire ttr_pkg::desc_t                       q_desc,
    output logic                                      q_pop,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [ttr_pkg::PIX_W-1:0]                 pixel_x,
    output logic [ttr_pkg::PIX_W-1:0]                 pixel_y,
    output logic signed [ttr_pkg::WEIGHT_W-1:0]       weight_a,
    output logic signed [ttr_pkg::WEIGHT_W-1:0]       weight_b,
    output logic signed [ttr_pkg::WEIGHT_W-1:0]       weight_c,
    output logic [1:0]                                status,
    output logic                                      last_of_run
);
    import ttr_pkg::*;
    `include "assert_macros.svh"

    localparam int IDX_W = $clog2(NUM_DIVS);

    back_state_t state_reg, state_next;
    desc_t       desc_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [PIX_W-1:0] cx_reg, cy_reg;
    qr_t rs_b_reg, rs_c_reg, cur_b_reg, cur_c_reg;
    qr_t col_b_reg, col_c_reg, row_b_reg, row_c_reg;

    logic                pend_valid_reg;
    logic [PIX_W-1:0]    pend_x_reg, pend_y_reg;
    logic [WEIGHT_W-1:0] pend_a_reg, pend_b_reg, pend_c_reg;

    logic                out_valid_reg;
    logic [PIX_W-1:0]    out_x_reg, out_y_reg;
    logic [WEIGHT_W-1:0] out_a_reg, out_b_reg, out_c_reg;
    status_t             out_status_reg;
    logic                out_last_reg;

    logic [PIX_W-1:0]    out_x_next, out_y_next;
    logic [WEIGHT_W-1:0] out_a_next, out_b_next, out_c_next;
    status_t             out_status_next;
    logic                out_last_next;

    logic out_free, out_load, latch_desc, div_store, scan_step;
    logic div_start, div_done;
    logic signed [NDIV_W-1:0] div_dividend;
    qr_t  div_res;

    logic signed [WA_W-1:0] wa, wb, wc, tolx;
    logic hit, row_end, box_end;
    qr_t  rs_b_adv, rs_c_adv;

    ttr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (desc_reg.dval),
        .done     (div_done),
        .result   (div_res)
    );

    always_comb
    begin
        case (idx_reg)
            IDX_W'(0): div_dividend = desc_reg.nb0;
            IDX_W'(1): div_dividend = desc_reg.nc0;
            IDX_W'(2): div_dividend = desc_reg.nbc;
            IDX_W'(3): div_dividend = desc_reg.ncc;
            IDX_W'(4): div_dividend = desc_reg.nbr;
            default:   div_dividend = desc_reg.ncr;
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign wb       = WA_W'(cur_b_reg.q);
    assign wc       = WA_W'(cur_c_reg.q);
    assign wa       = W_ONE - wb - wc;
    assign tolx     = WA_W'(tol);
    assign hit      = (wa >= tolx) && (wb >= tolx) && (wc >= tolx);
    assign row_end  = (cx_reg == desc_reg.bx1);
    assign box_end  = row_end && (cy_reg == desc_reg.by1);
    assign rs_b_adv = qr_add(rs_b_reg, row_b_reg, desc_reg.dval);
    assign rs_c_adv = qr_add(rs_c_reg, row_c_reg, desc_reg.dval);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (latch_desc)
            begin
                idx_reg        <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (div_store)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (scan_step && hit)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        q_pop           = 1'b0;
        div_start       = 1'b0;
        out_load        = 1'b0;
        latch_desc      = 1'b0;
        div_store       = 1'b0;
        scan_step       = 1'b0;
        out_x_next      = pend_x_reg;
        out_y_next      = pend_y_reg;
        out_a_next      = pend_a_reg;
        out_b_next      = pend_b_reg;
        out_c_next      = pend_c_reg;
        out_status_next = ST_COVERED;
        out_last_next   = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_desc.degen)
                    begin
                        if (out_free)
                        begin
                            out_load        = 1'b1;
                            q_pop           = 1'b1;
                            out_x_next      = '0;
                            out_y_next      = '0;
                            out_a_next      = '0;
                            out_b_next      = '0;
                            out_c_next      = '0;
                            out_status_next = ST_DEGEN;
                            out_last_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        latch_desc = 1'b1;
                        q_pop      = 1'b1;
                        state_next = B_DIV;
                    end
                end
            end
            B_DIV:
            begin
                div_start  = 1'b1;
                state_next = B_WAIT;
            end
            B_WAIT:
            begin
                if (div_done)
                begin
                    div_store  = 1'b1;
                    state_next = (idx_reg == IDX_W'(NUM_DIVS - 1)) ? B_SCAN : B_DIV;
                end
            end
            B_SCAN:
            begin
                if (out_free)
                begin
                    scan_step = 1'b1;
                    out_load  = hit && pend_valid_reg;
                    if (box_end)
                    begin
                        state_next = B_FINISH;
                    end
                end
            end
            B_FINISH:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_last_next = 1'b1;
                    if (!pend_valid_reg)
                    begin
                        out_x_next      = '0;
                        out_y_next      = '0;
                        out_a_next      = '0;
                        out_b_next      = '0;
                        out_c_next      = '0;
                        out_status_next = ST_NONE;
                    end
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (latch_desc)
        begin
            desc_reg <= q_desc;
            cx_reg   <= q_desc.bx0;
            cy_reg   <= q_desc.by0;
        end
        if (div_store)
        begin
            case (idx_reg)
                IDX_W'(0):
                begin
                    rs_b_reg  <= div_res;
                    cur_b_reg <= div_res;
                end
                IDX_W'(1):
                begin
                    rs_c_reg  <= div_res;
                    cur_c_reg <= div_res;
                end
                IDX_W'(2): col_b_reg <= div_res;
                IDX_W'(3): col_c_reg <= div_res;
                IDX_W'(4): row_b_reg <= div_res;
                default:   row_c_reg <= div_res;
            endcase
        end
        if (scan_step)
        begin
            if (hit)
            begin
                pend_x_reg <= cx_reg;
                pend_y_reg <= cy_reg;
                pend_a_reg <= sat_w(wa);
                pend_b_reg <= sat_w(wb);
                pend_c_reg <= sat_w(wc);
            end
            if (row_end)
            begin
                cx_reg    <= desc_reg.bx0;
                cy_reg    <= cy_reg + PIX_W'(1);
                rs_b_reg  <= rs_b_adv;
                rs_c_reg  <= rs_c_adv;
                cur_b_reg <= rs_b_adv;
                cur_c_reg <= rs_c_adv;
            end
            else
            begin
                cx_reg    <= cx_reg + PIX_W'(1);
                cur_b_reg <= qr_add(cur_b_reg, col_b_reg, desc_reg.dval);
                cur_c_reg <= qr_add(cur_c_reg, col_c_reg, desc_reg.dval);
            end
        end
        if (out_load)
        begin
            out_x_reg      <= out_x_next;
            out_y_reg      <= out_y_next;
            out_a_reg      <= out_a_next;
            out_b_reg      <= out_b_next;
            out_c_reg      <= out_c_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = out_x_reg;
    assign pixel_y     = out_y_reg;
    assign weight_a    = signed'(out_a_reg);
    assign weight_b    = signed'(out_b_reg);
    assign weight_c    = signed'(out_c_reg);
    assign status      = out_status_reg;
    assign last_of_run = out_last_reg;

    `ASSERT_IMPL(a_degen_last, out_valid_reg && out_status_reg == ST_DEGEN, out_last_reg,
        "degenerate result not marked last")
    `ASSERT_IMPL(a_none_zero, out_valid_reg && out_status_reg == ST_NONE,
        out_last_reg && out_a_reg == '0 && out_b_reg == '0 && out_c_reg == '0,
        "no-pixel result malformed")
    `ASSERT_IMPL(a_scan_in_box, state_reg == B_SCAN,
        cx_reg <= desc_reg.bx1 && cy_reg <= desc_reg.by1, "scan left the box")

endmodule

`default_nettype wire

// ===== sv/triangle_tile_rasterizer.sv =====
// ----------------------------------------------------------------------------
// triangle_tile_rasterizer
// barycentric rasterizer of one triangle per transfer in an 8x8 tile
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_stall   vertex0_x .. vertex2_y
//   out       output     out_valid / out_stall pixel_x, pixel_y, weight_a..c,
//                                              status, last_of_run
//   config    input      inside_tolerance_we   inside_tolerance
//
// front setup steps through delta, product, sum and push; the back runs six 34-step
// divisions, then scans one box pixel a cycle unless out_stall holds it, then closes
// a degenerate triangle is answered in the back's idle state, with no divisions
// a two-entry queue lets the front set up the next triangle during a scan
// out_stall freezes the scan; reset is asynchronous and sets tolerance to 0
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_tile_rasterizer (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 inside_tolerance_we,
    input  wire logic signed [ttr_pkg::WEIGHT_W-1:0]  inside_tolerance,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [ttr_pkg::COORD_W-1:0]          vertex0_x,
    input  wire logic [ttr_pkg::COORD_W-1:0]          vertex0_y,
    input  wire logic [ttr_pkg::COORD_W-1:0]          vertex1_x,
    input  wire logic [ttr_pkg::COORD_W-1:0]          vertex1_y,
    input  wire logic [ttr_pkg::COORD_W-1:0]          vertex2_x,
    input  wire logic [ttr_pkg::COORD_W-1:0]          vertex2_y,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [ttr_pkg::PIX_W-1:0]                 pixel_x,
    output logic [ttr_pkg::PIX_W-1:0]                 pixel_y,
    output logic signed [ttr_pkg::WEIGHT_W-1:0]       weight_a,
    output logic signed [ttr_pkg::WEIGHT_W-1:0]       weight_b,
    output logic signed [ttr_pkg::WEIGHT_W-1:0]       weight_c,
    output logic [1:0]                                status,
    output logic                                      last_of_run
);
    import ttr_pkg::*;

    logic signed [WEIGHT_W-1:0] tol_reg;
    logic  q_push, q_full, q_pop, q_valid;
    desc_t q_wdata, q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else if (inside_tolerance_we)
        begin
            tol_reg <= inside_tolerance;
        end
    end

    ttr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .vertex0_x (vertex0_x),
        .vertex0_y (vertex0_y),
        .vertex1_x (vertex1_x),
        .vertex1_y (vertex1_y),
        .vertex2_x (vertex2_x),
        .vertex2_y (vertex2_y),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    ttr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (q_rdata)
    );

    ttr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .tol         (tol_reg),
        .q_valid     (q_valid),
        .q_desc      (q_rdata),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .weight_a    (weight_a),
        .weight_b    (weight_b),
        .weight_c    (weight_c),
        .status      (status),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire
